// ----- hdl/crsg_pkg.sv -----
// Package for the circle rim line generator: widths, fixed-point constants,
// the Taylor-series divisor table and its reciprocals. No dependencies.
package crsg_pkg;
	localparam int SEG_W = 7;
	localparam int DIV_W = 13;
	localparam int RAD_W = 16;
	localparam int PT_W = 31;
	localparam int Q_W = 31;
	localparam logic [29:0] PI4_Q30 = 30'd843314857;
	localparam int NUM_TERMS = 6;
	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_MAX_DIVISIONS = 4096;

	typedef logic signed [PT_W-1:0] point_t;

	typedef struct packed {
		logic [Q_W-1:0] ts;
		logic [Q_W-1:0] tc;
		logic signed [Q_W+1:0] ss;
		logic signed [Q_W+1:0] cc;
	} term_t;

	function automatic logic [7:0] sin_div(input int n);
		sin_div = 8'((2 * n) * (2 * n + 1));
	endfunction

	function automatic logic [7:0] cos_div(input int n);
		cos_div = 8'((2 * n - 1) * (2 * n));
	endfunction

	// Multiplying a Q_W-bit value by this and shifting right by Q_W plus
	// clog2(d) gives the exact truncated quotient by d.
	function automatic logic [31:0] recip(input logic [7:0] d);
		longint unsigned p;
		p = 64'd1 << (Q_W + $clog2(d));
		recip = 32'((p + 64'(d) - 64'd1) / 64'(d));
	endfunction
endpackage

// ----- hdl/crsg_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// It has no dependencies.
module crsg_div #(
	parameter int NW = 44,
	parameter int DW = 17
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [NW-1:0] q_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0] trial;

	assign trial = {r_q[DW-1:0], q_q[NW-1]};
	assign quo = q_q;
	assign rem = r_q[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
				done <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				busy_q <= (cnt_q != CW'(1));
				done <= (cnt_q == CW'(1));
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- hdl/crsg_term_cell.sv -----
// One Taylor-series cell: multiplies both running terms by a*a, divides by
// the next factorial step with a reciprocal multiply and folds them into the sums.
module crsg_term_cell #(
	parameter int N = 1
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [crsg_pkg::Q_W-1:0] a2,
	input crsg_pkg::term_t din,
	output logic done,
	output crsg_pkg::term_t dout
);
	import crsg_pkg::*;
	localparam logic [7:0] SD = sin_div(N);
	localparam logic [7:0] CD = cos_div(N);
	localparam logic [31:0] SM = recip(SD);
	localparam logic [31:0] CM = recip(CD);
	localparam int SSH = Q_W + $clog2(SD);
	localparam int CSH = Q_W + $clog2(CD);
	logic [61:0] ps, pc;
	logic [Q_W-1:0] ms_q, mc_q;
	logic [62:0] qps, qpc;
	logic step_q;
	logic [Q_W-1:0] qs_q, qc_q;
	logic signed [Q_W+1:0] ss_q, cc_q;

	assign ps = din.ts * a2;
	assign pc = din.tc * a2;
	assign qps = ms_q * SM;
	assign qpc = mc_q * CM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			done <= 1'b0;
		end else begin
			step_q <= start;
			done <= step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ms_q <= ps[60:30];
			mc_q <= pc[60:30];
			ss_q <= din.ss;
			cc_q <= din.cc;
		end
		if (step_q) begin
			qs_q <= Q_W'(qps >> SSH);
			qc_q <= Q_W'(qpc >> CSH);
		end
	end

	always_comb begin
		dout.ts = qs_q;
		dout.tc = qc_q;
		if (N % 2 == 1) begin
			dout.ss = ss_q - $signed({2'b00, qs_q});
			dout.cc = cc_q - $signed({2'b00, qc_q});
		end else begin
			dout.ss = ss_q + $signed({2'b00, qs_q});
			dout.cc = cc_q + $signed({2'b00, qc_q});
		end
	end
endmodule

// ----- hdl/circle_rim_segment_generator_unit.sv -----
// Circle rim line generator top level: request intake, angle reduction,
// the chain of Taylor cells, rounding, radius scaling and output register.
// Depends on crsg_pkg, crsg_div and crsg_term_cell.
//
// A request of S segments, capped at MAX_SEGMENTS, yields S line
// transactions from rim point k to point k+1. Each rim point passes
// through a 20-bit serial division for the point index modulo D, two
// 44-bit serial divisions for the octant and the angle fraction, the
// steps for the angle and its square, the six Taylor cells, and the
// rounding, radius scaling and output steps. The first point is computed
// too, and m_tready can hold a line back. One request is processed at a
// time; s_tready is low while it is in work.
module circle_rim_segment_generator_unit #(
	parameter int MAX_SEGMENTS = crsg_pkg::DEF_MAX_SEGMENTS,
	parameter int MAX_DIVISIONS = crsg_pkg::DEF_MAX_DIVISIONS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// segment_count[6:0], division_count[19:7], radius_q8[35:20], zero fill
	input logic [39:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// start_x[30:0], start_y[61:31], end_x[92:62], end_y[123:93], zero fill
	output logic [127:0] m_tdata,
	output logic m_tlast
);
	import crsg_pkg::*;
	localparam logic [3:0] ST_IDLE = 4'd0, ST_MOD = 4'd1, ST_OCT = 4'd2, ST_FRAC = 4'd3,
		ST_ANG = 4'd4, ST_SQ = 4'd5, ST_TAY = 4'd6, ST_RND = 4'd7, ST_SCL = 4'd8,
		ST_OUT = 4'd9;

	logic [3:0] st_q;
	logic [SEG_W-1:0] segs_q, line_index_q;
	logic [16:0] divs_q;
	logic [RAD_W-1:0] rad_q;
	logic [SEG_W-1:0] pidx_q;
	logic [2:0] oct_q;
	logic [29:0] a_q;
	logic [Q_W-1:0] u_q;
	logic [Q_W-1:0] a2_q;
	logic first_q, go_q;
	point_t prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic signed [14:0] cv_q, sv_q;

	logic [SEG_W:0] segs_in;
	logic [16:0] divs_in;
	logic [16:0] num_w;
	logic dv1_start, dv1_done, dv2_start, dv2_done;
	logic [43:0] dv1_num, dv1_q;
	logic [16:0] dv1_r, dv2_r;
	logic [19:0] dv2_num, dv2_q;
	logic [60:0] aprod;
	logic [59:0] a2prod;
	logic take, out_load, out_last, next_pt;

	assign segs_in = {1'b0, s_tdata[6:0]} > (SEG_W+1)'(MAX_SEGMENTS) ?
		(SEG_W+1)'(MAX_SEGMENTS) : {1'b0, s_tdata[6:0]};
	assign divs_in = {4'd0, s_tdata[19:7]} > 17'(MAX_DIVISIONS) ?
		17'(MAX_DIVISIONS) : {4'd0, s_tdata[19:7]};
	assign s_tready = (st_q == ST_IDLE);

	assign take = s_tvalid && s_tready && segs_in != '0;
	assign out_last = (line_index_q + 1'b1 == segs_q);
	assign out_load = (st_q == ST_OUT) && !first_q && (!m_tvalid || m_tready);
	assign next_pt = (st_q == ST_OUT) && (first_q || (out_load && !out_last));

	// point index modulo D then 8*m split by D
	assign dv2_num = {13'd0, pidx_q};
	crsg_div #(.NW(20), .DW(17)) u_mod (.clk, .arst_n, .start(dv2_start),
		.num(dv2_num), .den(divs_q), .done(dv2_done), .quo(dv2_q), .rem(dv2_r));
	assign num_w = dv1_q[0] ? divs_q - dv1_r : dv1_r;
	crsg_div #(.NW(44), .DW(17)) u_frac (.clk, .arst_n, .start(dv1_start),
		.num(dv1_num), .den(divs_q), .done(dv1_done), .quo(dv1_q), .rem(dv1_r));

	// Taylor chain
	term_t chain [0:NUM_TERMS];
	logic cdone [0:NUM_TERMS];
	assign chain[0] = {{1'b0, a_q}, 31'h4000_0000, {3'b000, a_q}, 33'h0_4000_0000};
	assign cdone[0] = go_q;
	for (genvar g = 1; g <= NUM_TERMS; g++) begin : g_cell
		crsg_term_cell #(.N(g)) u_cell (.clk, .arst_n, .start(cdone[g-1]),
			.a2(a2_q), .din(chain[g-1]), .done(cdone[g]), .dout(chain[g]));
	end

	function automatic logic signed [14:0] rnd4(input logic signed [Q_W+1:0] m);
		logic [47:0] v;
		logic [Q_W+1:0] mm;
		mm = m < 0 ? '0 : m;
		v = 48'(mm) * 48'd10000 + 48'h2000_0000;
		rnd4 = (v[47:30] > 18'd10000) ? 15'sd10000 : 15'(v[47:30]);
	endfunction

	logic signed [14:0] sr, cr;
	assign sr = rnd4(chain[NUM_TERMS].ss);
	assign cr = rnd4(chain[NUM_TERMS].cc);
	assign aprod = u_q * PI4_Q30 + 61'h2000_0000;
	assign a2prod = a_q * a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv2_start <= 1'b0;
			dv1_start <= 1'b0;
			go_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			dv2_start <= take || next_pt;
			dv1_start <= (st_q == ST_MOD && dv2_done) || (st_q == ST_OCT && dv1_done);
			go_q <= (st_q == ST_SQ);
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			line_index_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (take) begin
						segs_q <= segs_in[SEG_W-1:0];
						divs_q <= divs_in;
						rad_q <= s_tdata[35:20];
						pidx_q <= '0;
						first_q <= 1'b1;
						line_index_q <= '0;
						st_q <= ST_MOD;
					end
				end
				ST_MOD: if (dv2_done) begin
					dv1_num <= 44'({dv2_r, 3'b000});
					st_q <= ST_OCT;
				end
				ST_OCT: if (dv1_done) begin
					oct_q <= dv1_q[2:0];
					dv1_num <= {num_w[13:0], 30'd0};
					st_q <= ST_FRAC;
				end
				ST_FRAC: if (dv1_done) begin
					u_q <= dv1_q[Q_W-1:0];
					st_q <= ST_ANG;
				end
				ST_ANG: begin
					a_q <= aprod[59:30];
					st_q <= ST_SQ;
				end
				ST_SQ: begin
					a2_q <= {1'b0, a2prod[59:30]};
					st_q <= ST_TAY;
				end
				ST_TAY: begin
					if (cdone[NUM_TERMS]) begin
						st_q <= ST_RND;
					end
				end
				ST_RND: begin
					if (divs_q == '0) begin
						cv_q <= 15'sd10000;
						sv_q <= '0;
					end else begin
						case (oct_q)
							3'd0: begin cv_q <= cr; sv_q <= sr; end
							3'd1: begin cv_q <= sr; sv_q <= cr; end
							3'd2: begin cv_q <= -sr; sv_q <= cr; end
							3'd3: begin cv_q <= -cr; sv_q <= sr; end
							3'd4: begin cv_q <= -cr; sv_q <= -sr; end
							3'd5: begin cv_q <= -sr; sv_q <= -cr; end
							3'd6: begin cv_q <= sr; sv_q <= -cr; end
							default: begin cv_q <= cr; sv_q <= -sr; end
						endcase
					end
					st_q <= ST_SCL;
				end
				ST_SCL: begin
					cur_x_q <= PT_W'($signed({1'b0, rad_q}) * cv_q);
					cur_y_q <= PT_W'($signed({1'b0, rad_q}) * sv_q);
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (first_q) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						first_q <= 1'b0;
						pidx_q <= pidx_q + 1'b1;
						st_q <= ST_MOD;
					end else if (out_load) begin
						m_tdata <= {4'd0, cur_y_q, cur_x_q, prev_y_q, prev_x_q};
						m_tlast <= out_last;
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						line_index_q <= line_index_q + 1'b1;
						if (out_last) begin
							st_q <= ST_IDLE;
						end else begin
							pidx_q <= pidx_q + 1'b1;
							st_q <= ST_MOD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for circle_rim_segment_generator_unit: a directed table and random
// requests, with each line transaction checked against a fixed-point rim point predictor.
// Depends on crsg_pkg and the generator RTL.
`timescale 1ns / 1ps

module testbench;
	import crsg_pkg::*;

	localparam int MAX_SEG = 64;
	localparam int MAX_DIV = 4096;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 800;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	typedef struct {
		point_t sx;
		point_t sy;
		point_t ex;
		point_t ey;
		bit last;
	} rim_line_t;

	typedef struct {
		int segs;
		int divs;
		int rad;
		bit fixed;
		longint fx;
		longint fy;
	} request_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [127:0] m_tdata;
	logic m_tlast;

	rim_line_t rim_lines_q[$];
	int failures = 0;
	int lines_seen = 0;
	int requests_sent = 0;
	bit quiet = 0;
	bit hold_request = 0;
	int hold_left = 0;
	longint cycles = 0;

	circle_rim_segment_generator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint round_to_1e4(longint m);
		longint unsigned v;
		if (m < 0) begin
			m = 0;
		end
		v = (longint'(m) * 64'd10000 + (64'd1 << 29)) >> 30;
		if (v > 10000) begin
			v = 10000;
		end
		return longint'(v);
	endfunction

	task automatic rim_point(input longint unsigned n, input longint unsigned d,
			output longint c, output longint s);
		longint unsigned m, t, o, r, num, u, a, a2, ts, tc;
		longint ss, cc, sv, cv;
		if (d == 0) begin
			c = 10000;
			s = 0;
			return;
		end
		m = n % d;
		t = m * 8;
		o = (t / d) & 7;
		r = t % d;
		num = o[0] ? (d - r) : r;
		u = (num << 30) / d;
		a = (u * longint'(PI4_Q30) + (64'd1 << 29)) >> 30;
		a2 = (a * a) >> 30;
		ts = a;
		tc = Q30_ONE;
		ss = longint'(a);
		cc = longint'(Q30_ONE);
		for (int k = 1; k <= 6; k++) begin
			ts = ((ts * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
			tc = ((tc * a2) >> 30) / longint'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				ss -= longint'(ts);
				cc -= longint'(tc);
			end else begin
				ss += longint'(ts);
				cc += longint'(tc);
			end
		end
		sv = round_to_1e4(ss);
		cv = round_to_1e4(cc);
		case (o)
			0: begin c = cv; s = sv; end
			1: begin c = sv; s = cv; end
			2: begin c = -sv; s = cv; end
			3: begin c = -cv; s = sv; end
			4: begin c = -cv; s = -sv; end
			5: begin c = -sv; s = -cv; end
			6: begin c = sv; s = -cv; end
			default: begin c = cv; s = -sv; end
		endcase
	endtask

	task automatic predict_rim_lines(input request_row_t row);
		int segs, divs;
		longint c, s, px, py, nx, ny;
		rim_line_t ln;
		segs = row.segs;
		divs = row.divs;
		if (segs == 0) begin
			return;
		end
		if (segs > MAX_SEG) begin
			segs = MAX_SEG;
		end
		if (divs > MAX_DIV) begin
			divs = MAX_DIV;
		end
		rim_point(0, divs, c, s);
		px = row.rad * c;
		py = row.rad * s;
		for (int k = 0; k < segs; k++) begin
			rim_point(k + 1, divs, c, s);
			nx = row.rad * c;
			ny = row.rad * s;
			if (row.fixed) begin
				px = row.fx;
				py = row.fy;
				nx = row.fx;
				ny = row.fy;
			end
			ln.sx = point_t'(px);
			ln.sy = point_t'(py);
			ln.ex = point_t'(nx);
			ln.ey = point_t'(ny);
			ln.last = (k + 1 == segs);
			rim_lines_q.push_back(ln);
			px = nx;
			py = ny;
		end
	endtask

	task automatic send_request(input request_row_t row);
		while (!quiet && $urandom_range(0, 99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, row.rad[15:0], row.divs[12:0], row.segs[6:0]};
		do
			@(posedge clk);
		while (!s_tready);
		predict_rim_lines(row);
		requests_sent++;
	endtask

	always @(posedge clk) begin
		rim_line_t want;
		point_t got_sx, got_sy, got_ex, got_ey;
		if (m_tvalid && m_tready) begin
			got_sx = m_tdata[30:0];
			got_sy = m_tdata[61:31];
			got_ex = m_tdata[92:62];
			got_ey = m_tdata[123:93];
			lines_seen++;
			if (rim_lines_q.size() == 0) begin
				$error("unexpected line transaction");
				failures++;
			end else begin
				want = rim_lines_q.pop_front();
				if (got_sx !== want.sx) begin
					$error("start_x expected %0d actual %0d", want.sx, got_sx);
					failures++;
				end
				if (got_sy !== want.sy) begin
					$error("start_y expected %0d actual %0d", want.sy, got_sy);
					failures++;
				end
				if (got_ex !== want.ex) begin
					$error("end_x expected %0d actual %0d", want.ex, got_ex);
					failures++;
				end
				if (got_ey !== want.ey) begin
					$error("end_y expected %0d actual %0d", want.ey, got_ey);
					failures++;
				end
				if (m_tlast !== want.last) begin
					$error("last_line expected %0d actual %0d", want.last, m_tlast);
					failures++;
				end
			end
		end
		if (hold_request && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_request = 0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 26);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		request_row_t table_rows[$];
		request_row_t row;
		int wait_cycles;
		int pick;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_rows = '{
			'{1, 4, 256, 0, 0, 0},
			'{0, 8, 1000, 0, 0, 0},
			'{1, 0, 100, 1, 1000000, 0},
			'{3, 0, 65535, 1, 655350000, 0},
			'{5, 1, 300, 1, 3000000, 0},
			'{2, 8, 0, 1, 0, 0},
			'{0, 8191, 65535, 0, 0, 0},
			'{4, 4, 65535, 0, 0, 0},
			'{8, 8, 12345, 0, 0, 0},
			'{6, 3, 777, 0, 0, 0},
			'{10, 7, 4000, 0, 0, 0},
			'{16, 16, 256, 0, 0, 0},
			'{64, 4096, 65535, 0, 0, 0},
			'{127, 8191, 65535, 0, 0, 0},
			'{65, 5000, 43690, 0, 0, 0},
			'{12, 4097, 21845, 0, 0, 0},
			'{9, 4095, 1, 0, 0, 0},
			'{7, 2, 32768, 0, 0, 0},
			'{3, 360, 51234, 0, 0, 0},
			'{1, 6, 65535, 0, 0, 0}
		};
		foreach (table_rows[i]) begin
			send_request(table_rows[i]);
		end

		hold_request = 1;
		for (int i = 0; i < 80; i++) begin
			quiet = (i >= 30 && i < 50);
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				row.segs = 64;
			end else if (pick < 9) begin
				row.segs = $urandom_range(0, 127);
			end else begin
				row.segs = $urandom_range(0, 8);
			end
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				row.divs = $urandom_range(0, 8191);
			end else if (pick < 8) begin
				row.divs = $urandom_range(1, 4096);
			end else begin
				row.divs = $urandom_range(0, 16);
			end
			row.rad = $urandom_range(0, 65535);
			row.fixed = 0;
			row.fx = 0;
			row.fy = 0;
			send_request(row);
		end
		quiet = 0;
		s_tvalid <= 1'b0;

		while (rim_lines_q.size() != 0) begin
			@(posedge clk);
		end
		wait_cycles = DRAIN_CYCLES;
		repeat (wait_cycles) @(posedge clk);

		$display("Sent %0d circle requests, checked %0d rim line transactions.",
			requests_sent, lines_seen);
		$display("Covered saturation, zero divisions, zero radius and a long output stall.");
		if (failures == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule

// ----- files.f -----
hdl/crsg_pkg.sv
hdl/crsg_div.sv
hdl/crsg_term_cell.sv
hdl/circle_rim_segment_generator_unit.sv
dv/testbench.sv
